// ===== src/tbu16_pkg.sv =====
// Shared types, register indexes and helper functions for the byte-stream
// to UTF-16 decoder. No dependencies.
package tbu16_pkg;

  // Source encodings selected by the mode register.
  typedef enum logic [1:0] {
    MODE_ASCII    = 2'd0,
    MODE_UTF8     = 2'd1,
    MODE_UTF16_LE = 2'd2,
    MODE_UTF16_BE = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ENCODING_MODE    = 2'd0,
    REG_ERROR_ACTION     = 2'd1,
    REG_REPLACEMENT_UNIT = 2'd2,
    REG_UNUSED           = 2'd3
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam mode_e       ModeReset        = MODE_UTF8;
  localparam logic        ErrorActionReset = 1'b0;
  localparam logic [15:0] ReplUnitReset    = 16'hFFFD;

  localparam logic [31:0] MaxCodePoint  = 32'h0010_FFFF;
  localparam logic [31:0] UpperHalfMask = 32'hFFFF_0000;
  localparam logic [31:0] SuppBase      = 32'h0001_0000;
  localparam logic [15:0] HighSurrBase  = 16'hD800;
  localparam logic [15:0] LowSurrBase   = 16'hDC00;
  localparam logic [7:0]  AsciiMax      = 8'h7F;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       block_end;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        bad_char;
    logic        run_last;
    logic        block_done;
  } out_t;

  // Number of continuation bytes announced by a UTF-8 lead byte.
  function automatic logic [2:0] lead_extra(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    case (b) inside
      [8'hC0:8'hDF]: n = 3'd1;
      [8'hE0:8'hEF]: n = 3'd2;
      [8'hF0:8'hF7]: n = 3'd3;
      [8'hF8:8'hFB]: n = 3'd4;
      [8'hFC:8'hFF]: n = 3'd5;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  // Offset removed from the folded sequence, by number of continuation bytes.
  function automatic logic [31:0] utf8_offset(input logic [2:0] len);
    logic [31:0] o;
    case (len)
      3'd0:    o = 32'h0000_0000;
      3'd1:    o = 32'h0000_3080;
      3'd2:    o = 32'h000E_2080;
      3'd3:    o = 32'h03C8_2080;
      3'd4:    o = 32'hFA08_2080;
      default: o = 32'h8208_2080;
    endcase
    return o;
  endfunction

endpackage

// ===== src/text_bytes_to_utf16_decoder_core.sv =====
// Top level of the byte-stream to UTF-16 decoder: decode logic, pending
// sequence state, configuration registers and the result queue.
// Depends on tbu16_pkg.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | in_valid_i/stall_o  | tbu16_pkg::in_t  (byte, block end)
//   out     | output    | out_valid_o/stall_i | tbu16_pkg::out_t (zero or one unit)
//   cfg     | input     | cfg_valid_i/ready_o | register index and write data
//
// One source byte is accepted per cycle unless the input stalls. The byte is
// decoded in the cycle it is accepted and its zero, one or two results are
// written into a four-entry queue that feeds the output. A byte that yields
// a surrogate pair queues two results, drained one at a time. The input
// stalls only while the queue holds more than two results, which is a
// registered condition with no path from out_stall_i. Reset clears the
// configuration to its defaults, drops any pending sequence and empties the
// queue. Configuration writes are always accepted.
module text_bytes_to_utf16_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tbu16_pkg::in_t                    in_data_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tbu16_pkg::out_t                   out_data_o,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbu16_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tbu16_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tbu16_pkg::*;

  // Configuration registers.
  mode_e       mode_q;
  logic        err_action_q;
  logic [15:0] repl_unit_q;

  // Pending sequence state.
  logic [2:0]  bytes_rem_q,  bytes_rem_d;
  logic [2:0]  seq_len_q,    seq_len_d;
  logic [31:0] acc_q,        acc_d;
  logic [7:0]  held_byte_q,  held_byte_d;
  logic        held_valid_q, held_valid_d;

  // Result queue. Entries are payload only; pointers and count are control.
  out_t        queue_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;

  logic        in_accept, out_accept, cfg_write;
  out_t        res0, res1, bad_res;
  logic [1:0]  n_res;
  logic [7:0]  b;
  logic [31:0] acc_shift, code_val, supp_val;
  logic [2:0]  extra;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // The queue must have room for the two results a byte may produce.
  assign in_stall_o  = (count_q > 3'd2);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 3'd0);
  assign out_accept  = out_valid_o && !out_stall_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  assign b         = in_data_i.source_byte;
  assign acc_shift = {acc_q[25:0], 6'd0} + {24'd0, b};
  assign code_val  = acc_shift - utf8_offset(seq_len_q);
  assign supp_val  = code_val - SuppBase;
  assign extra     = lead_extra(b);

  // A bad character becomes either the replacement unit or an error flag.
  always_comb begin
    bad_res = '0;
    if (err_action_q) begin
      bad_res.bad_char = 1'b1;
    end else begin
      bad_res.code_unit = repl_unit_q;
      bad_res.has_unit  = 1'b1;
    end
  end

  // Decode one byte against the pending state.
  always_comb begin
    bytes_rem_d  = bytes_rem_q;
    seq_len_d    = seq_len_q;
    acc_d        = acc_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;

    case (mode_q)
      MODE_ASCII: begin
        n_res = 2'd1;
        if (b == 8'd0 || b > AsciiMax) begin
          res0 = bad_res;
        end else begin
          res0.code_unit = {8'd0, b};
          res0.has_unit  = 1'b1;
        end
      end
      MODE_UTF8: begin
        if (bytes_rem_q == 3'd0) begin
          if (extra == 3'd0) begin
            // Plain ASCII and stray continuation bytes pass through.
            res0.code_unit = {8'd0, b};
            res0.has_unit  = 1'b1;
            n_res          = 2'd1;
          end else begin
            acc_d       = {24'd0, b};
            seq_len_d   = extra;
            bytes_rem_d = extra;
          end
        end else begin
          bytes_rem_d = bytes_rem_q - 3'd1;
          if (bytes_rem_q == 3'd1) begin
            seq_len_d = 3'd0;
            acc_d     = '0;
            if ((code_val & UpperHalfMask) == 32'd0) begin
              res0.code_unit = code_val[15:0];
              res0.has_unit  = 1'b1;
              n_res          = 2'd1;
            end else if (code_val > MaxCodePoint) begin
              res0  = bad_res;
              n_res = 2'd1;
            end else begin
              res0.code_unit = {6'd0, supp_val[19:10]} + HighSurrBase;
              res0.has_unit  = 1'b1;
              res1.code_unit = {6'd0, supp_val[9:0]} + LowSurrBase;
              res1.has_unit  = 1'b1;
              n_res          = 2'd2;
            end
          end else begin
            acc_d = acc_shift;
          end
        end
      end
      default: begin
        // Both UTF-16 byte orders pair up two bytes into one unit.
        if (!held_valid_q) begin
          held_byte_d  = b;
          held_valid_d = 1'b1;
        end else begin
          held_byte_d    = 8'd0;
          held_valid_d   = 1'b0;
          res0.has_unit  = 1'b1;
          n_res          = 2'd1;
          if (mode_q == MODE_UTF16_LE) begin
            res0.code_unit = {b, held_byte_q};
          end else begin
            res0.code_unit = {held_byte_q, b};
          end
        end
      end
    endcase

    // A block end always reports, even when nothing was completed.
    if (n_res == 2'd0 && in_data_i.block_end) begin
      res0  = '0;
      n_res = 2'd1;
    end

    if (n_res == 2'd2) begin
      res1.run_last   = 1'b1;
      res1.block_done = in_data_i.block_end;
    end else begin
      res0.run_last   = 1'b1;
      res0.block_done = in_data_i.block_end;
    end
  end

  // Configuration and pending state. A mode write drops any pending sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeReset;
      err_action_q <= ErrorActionReset;
      repl_unit_q  <= ReplUnitReset;
      bytes_rem_q  <= '0;
      seq_len_q    <= '0;
      acc_q        <= '0;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ENCODING_MODE: begin
          mode_q       <= mode_e'(cfg_data_i[1:0]);
          bytes_rem_q  <= '0;
          seq_len_q    <= '0;
          acc_q        <= '0;
          held_byte_q  <= '0;
          held_valid_q <= 1'b0;
        end
        REG_ERROR_ACTION:     err_action_q <= cfg_data_i[0];
        REG_REPLACEMENT_UNIT: repl_unit_q  <= cfg_data_i;
        default: ;
      endcase
    end else if (in_accept) begin
      bytes_rem_q  <= bytes_rem_d;
      seq_len_q    <= seq_len_d;
      acc_q        <= acc_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
    end
  end

  // Result queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr_q <= wr_ptr_q + n_res;
      end
      if (out_accept) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (in_accept ? {1'b0, n_res} : 3'd0)
                         - (out_accept ? 3'd1 : 3'd0);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      queue_q[wr_ptr_q] <= res0;
      if (n_res == 2'd2) begin
        queue_q[wr_ptr_q + 2'd1] <= res1;
      end
    end
  end

endmodule
